/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, masked while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* rtl/xbiq_pkg.sv */
// ----------------------------------------------------------------------------
// xbiq_pkg
// Shared constants and types of the XOR basis insert/query block.
// ----------------------------------------------------------------------------
`default_nettype none

package xbiq_pkg;

    localparam int WIDTH_DEF = 64;
    localparam int CELL_ROWS = 8;
    localparam int RANK_W    = 7;

    typedef struct packed {
        logic clear;
        logic update;
    } t_cell_ctrl;

endpackage

`default_nettype wire

/* rtl/xbiq_cell.sv */
// ----------------------------------------------------------------------------
// xbiq_cell
// One cell of the basis chain: holds a few pivot rows, folds them into the
// passing remainder and registers it for the next cell down.
// ----------------------------------------------------------------------------
`default_nettype none

module xbiq_cell #(
    parameter int WIDTH = xbiq_pkg::WIDTH_DEF,
    parameter int ROWS  = xbiq_pkg::CELL_ROWS,
    parameter int BASE  = 0
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire xbiq_pkg::t_cell_ctrl i_ctrl,
    input  wire logic [WIDTH-1:0]    i_part,
    input  wire logic [WIDTH-1:0]    i_rem,
    input  wire logic [WIDTH-1:0]    i_top,
    output logic      [WIDTH-1:0]    o_part
);

    logic [WIDTH-1:0] contrib [ROWS];
    logic [WIDTH-1:0] r_part, n_part;

    for (genvar j = 0; j < ROWS; j++) begin : g_slot
        localparam int IDX = BASE + j;
        if (IDX < WIDTH) begin : g_row
            logic [WIDTH-1:0] r_row, n_row;

            always_comb begin
                n_row = r_row;
                if (i_ctrl.clear) begin
                    n_row = '0;
                end else if (i_ctrl.update) begin
                    if (i_top[IDX]) begin
                        n_row = i_rem;
                    end else if (|(r_row & i_top)) begin
                        n_row = r_row ^ i_rem;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_row <= '0;
                end else begin
                    r_row <= n_row;
                end
            end

            // pivot bits of the word are untouched above this row
            assign contrib[j] = i_part[IDX] ? r_row : '0;
        end else begin : g_none
            assign contrib[j] = '0;
        end
    end

    always_comb begin
        n_part = i_part;
        for (int j = 0; j < ROWS; j++) begin
            n_part = n_part ^ contrib[j];
        end
    end

    always_ff @(posedge i_clk) begin
        r_part <= n_part;
    end

    assign o_part = r_part;

endmodule

`default_nettype wire

/* rtl/xor_basis_insert_query.sv */
// ----------------------------------------------------------------------------
// xor_basis_insert_query
// Reduced XOR basis over GF(2): insert a word, report added, rank, max XOR.
// ----------------------------------------------------------------------------
//  channel | valid    | stall    | payload
//  in      | i_valid  | o_stall  | i_clear_first, i_value
//  out     | o_valid  | i_stall  | o_added, o_rank, o_max_xor
//
//  The cell chain has NCELL = WIDTH/8 rounded up cells. After accept the remainder
//  walks the chain one cell per cycle, then an update step writes the rows and the result.
//  The input reopens the cycle after the update; no new request is taken before it.
//  Reset clears all rows, rank and max XOR at once; no clearing pass.
//  A finished result waits in the output register; the next request is taken
//  meanwhile, and only its update cycle waits for the output to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_basis_insert_query #(
    parameter int WIDTH = xbiq_pkg::WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_clear_first,
    input  wire logic [WIDTH-1:0]            i_value,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic                             o_added,
    output logic [xbiq_pkg::RANK_W-1:0]      o_rank,
    output logic [WIDTH-1:0]                 o_max_xor
);

    import xbiq_pkg::*;

    `include "assert_macros.svh"

    localparam int NCELL = (WIDTH + CELL_ROWS - 1) / CELL_ROWS;
    localparam int RW    = $clog2(WIDTH + 1);
    localparam int CW    = $clog2(NCELL + 1);
    localparam int SW    = $clog2(WIDTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [WIDTH-1:0] r_word;
    logic [WIDTH-1:0] r_acc, n_acc;
    logic [RW-1:0]    r_rank, n_rank;

    logic              r_out_valid, n_out_valid;
    logic              r_out_added;
    logic [RANK_W-1:0] r_out_rank;
    logic [WIDTH-1:0]  r_out_max;

    logic [WIDTH-1:0] part [NCELL+1];
    logic [WIDTH-1:0] rem, smear, top;
    logic             accept, added, acc_at_top, fire;
    t_cell_ctrl       ctrl;

    assign o_stall = (r_state != ST_IDLE);
    assign accept  = i_valid && !o_stall;

    assign part[NCELL] = r_word;

    for (genvar c = 0; c < NCELL; c++) begin : g_cell
        xbiq_cell #(
            .WIDTH (WIDTH),
            .ROWS  (CELL_ROWS),
            .BASE  (c * CELL_ROWS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl),
            .i_part  (part[c+1]),
            .i_rem   (rem),
            .i_top   (top),
            .o_part  (part[c])
        );
    end

    assign rem = part[0];

    // leading one of the remainder as a one-hot mask
    always_comb begin
        smear = rem;
        for (int k = 0; k < SW; k++) begin
            smear = smear | (smear >> (1 << k));
        end
        top = smear & ~(smear >> 1);
    end

    assign added      = |rem;
    assign acc_at_top = |(r_acc & top);
    assign fire       = (r_state == ST_UPDATE) && (!r_out_valid || !i_stall);

    assign ctrl.clear  = accept && i_clear_first;
    assign ctrl.update = fire && added;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SWEEP;
                    n_cnt   = '0;
                end
            end
            ST_SWEEP: begin
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(NCELL - 1)) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // new row flips bit p of every row holding it; parity decides the max
    always_comb begin
        n_acc  = r_acc;
        n_rank = r_rank;
        if (ctrl.clear) begin
            n_acc  = '0;
            n_rank = '0;
        end else if (ctrl.update) begin
            n_rank = r_rank + RW'(1);
            n_acc  = acc_at_top ? r_acc : (r_acc ^ rem);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_acc       <= '0;
            r_rank      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_acc       <= n_acc;
            r_rank      <= n_rank;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= i_value;
        end
        if (fire) begin
            r_out_added <= added;
            r_out_rank  <= RANK_W'(n_rank);
            r_out_max   <= n_acc;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_added   = r_out_added;
    assign o_rank    = r_out_rank;
    assign o_max_xor = r_out_max;

    `ASSERT_CLK(a_rank_range, r_rank <= RW'(WIDTH), "rank above word width")
    `ASSERT_CLK(a_added_rank, (o_valid && o_added) |-> (o_rank != '0), "added with rank zero")
    `ASSERT_CLK(a_rank_step, ctrl.update |=> (r_rank == $past(r_rank) + RW'(1)), "rank step")
    `ASSERT_CLK(a_top_onehot, ((r_state == ST_UPDATE) && added) |-> $onehot(top), "pivot mask")

endmodule

`default_nettype wire

/* tb/tb_xor_basis_insert_query.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_xor_basis_insert_query
// Self-checking testbench for the reduced XOR basis block. Each accepted
// request is applied to a private copy of the basis rows. That copy gives the
// expected added flag, rank and maximum XOR, which are compared in order with
// the results. Directed words come first, then random insert sequences, each
// opened by a clear. Both handshakes see random gaps, one long output hold
// and one full drain.
// ----------------------------------------------------------------------------

typedef logic [xbiq_pkg::WIDTH_DEF-1:0] t_basis_word;

typedef struct packed {
    logic                          added;
    logic [xbiq_pkg::RANK_W-1:0]   rank;
    t_basis_word                   max_xor;
} t_basis_result;

class xor_basis_scoreboard;
    t_basis_word   basis_row [xbiq_pkg::WIDTH_DEF];
    t_basis_result expected_q [$];
    int            errors;

    function new();
        foreach (basis_row[i]) basis_row[i] = '0;
        errors = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // reduce by the pivots; a new row is reduced below and cleared out above
    function bit absorb_word(t_basis_word word);
        t_basis_word rem;
        int          j;
        int          k;
        rem = word;
        for (j = xbiq_pkg::WIDTH_DEF - 1; j >= 0; j--) begin
            if (rem == '0) return 1'b0;
            if (rem[j]) begin
                if (basis_row[j] != '0) begin
                    rem ^= basis_row[j];
                end else begin
                    for (k = 0; k < j; k++)
                        if (rem[k]) rem ^= basis_row[k];
                    for (k = j + 1; k < xbiq_pkg::WIDTH_DEF; k++)
                        if (basis_row[k][j]) basis_row[k] ^= rem;
                    basis_row[j] = rem;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function void note_request(logic clear_first, t_basis_word word);
        t_basis_result res;
        int            nonzero;
        if (clear_first) begin
            foreach (basis_row[i]) basis_row[i] = '0;
        end
        res.added   = absorb_word(word);
        res.max_xor = '0;
        nonzero     = 0;
        foreach (basis_row[i]) begin
            if (basis_row[i] != '0) nonzero++;
            res.max_xor ^= basis_row[i];
        end
        res.rank = nonzero[xbiq_pkg::RANK_W-1:0];
        expected_q = {expected_q, res};
    endfunction

    function void check_result(logic added, logic [xbiq_pkg::RANK_W-1:0] rank,
                               t_basis_word max_xor);
        t_basis_result want;
        if (expected_q.size() == 0) begin
            $error("result with no request outstanding: added %0d rank %0d max_xor %h",
                   added, rank, max_xor);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (added !== want.added) begin
            $error("added: expected %0d, got %0d", want.added, added);
            errors++;
        end
        if (rank !== want.rank) begin
            $error("rank: expected %0d, got %0d", want.rank, rank);
            errors++;
        end
        if (max_xor !== want.max_xor) begin
            $error("max_xor: expected %h, got %h", want.max_xor, max_xor);
            errors++;
        end
    endfunction
endclass

module tb_xor_basis_insert_query;

    localparam int WIDTH       = xbiq_pkg::WIDTH_DEF;
    localparam int RANDOM_REQS = 600;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_AT    = 350;
    localparam int TAIL_CYCLES = 40;
    localparam int LIMIT       = 300000;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic                        i_clear_first;
    t_basis_word                 i_value;
    logic                        o_valid;
    logic                        i_stall;
    logic                        o_added;
    logic [xbiq_pkg::RANK_W-1:0] o_rank;
    t_basis_word                 o_max_xor;

    xor_basis_scoreboard sb;
    int                  sent_total = 0;
    int                  cycle_count = 0;
    bit                  hold_done = 1'b0;

    xor_basis_insert_query #(
        .WIDTH (WIDTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_clear_first (i_clear_first),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_added       (o_added),
        .o_rank        (o_rank),
        .o_max_xor     (o_max_xor)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count <= LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_added, o_rank, o_max_xor);
    end

    function automatic int pick_gap(bit no_gaps);
        int pct;
        pct = $urandom_range(0, 99);
        if (no_gaps || pct < 55) return 0;
        if (pct < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic push_request(input logic clr, input t_basis_word word, input int gap);
        i_valid       <= 1'b1;
        i_clear_first <= clr;
        i_value       <= word;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(clr, word);
        sent_total++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // output side: random stall runs, one long hold once traffic is flowing
    initial begin
        int run_left;
        int hold_left;
        int pct;
        bit stalling;
        run_left  = 0;
        hold_left = 0;
        stalling  = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && sent_total >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    stalling = !stalling;
                    pct      = $urandom_range(0, 99);
                    if (!stalling)
                        run_left = (pct < 12) ? $urandom_range(30, 120) : $urandom_range(1, 6);
                    else if (pct < 60)
                        run_left = $urandom_range(1, 2);
                    else if (pct < 90)
                        run_left = $urandom_range(3, 6);
                    else
                        run_left = $urandom_range(10, 30);
                end
                run_left--;
                i_stall <= stalling;
            end
        end
    end

    initial begin
        t_basis_word history [$];
        t_basis_word word;
        t_basis_word ones;
        int          rnd_sent;
        int          seq_len;
        int          n;
        int          m;
        int          kind;
        int          lo;
        int          hi;
        bit          no_gaps;
        bit          drain_done;
        logic        clr;

        sb            = new();
        ones          = '1;
        rnd_sent      = 0;
        drain_done    = 1'b0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_clear_first <= 1'b0;
        i_value       <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero word, dependent words, clears, extreme patterns
        push_request(1'b0, '0, pick_gap(1'b0));
        push_request(1'b0, ones, pick_gap(1'b0));
        push_request(1'b0, ones, pick_gap(1'b0));
        push_request(1'b0, 64'h0000_0000_0000_0001, pick_gap(1'b0));
        push_request(1'b0, 64'h8000_0000_0000_0000, pick_gap(1'b0));
        push_request(1'b0, 64'h8000_0000_0000_0001, pick_gap(1'b0));
        push_request(1'b0, '0, pick_gap(1'b0));
        push_request(1'b1, '0, pick_gap(1'b0));
        push_request(1'b1, 64'hA5A5_A5A5_A5A5_A5A5, pick_gap(1'b0));
        push_request(1'b0, 64'h5A5A_5A5A_5A5A_5A5A, pick_gap(1'b0));
        push_request(1'b0, ones, pick_gap(1'b0));
        push_request(1'b1, 64'h8000_0000_0000_0000, pick_gap(1'b0));
        push_request(1'b0, 64'h5555_5555_5555_5555, pick_gap(1'b0));
        push_request(1'b0, 64'hAAAA_AAAA_AAAA_AAAA, pick_gap(1'b0));
        push_request(1'b0, 64'h0000_0000_FFFF_FFFF, pick_gap(1'b0));
        push_request(1'b0, 64'hFFFF_FFFF_0000_0000, pick_gap(1'b0));
        push_request(1'b0, 64'h0123_4567_89AB_CDEF, pick_gap(1'b0));
        push_request(1'b0, 64'h0000_0000_8000_0000, pick_gap(1'b0));
        push_request(1'b1, 64'h0000_0000_0000_0001, pick_gap(1'b0));
        push_request(1'b0, 64'h0000_0000_0000_0003, pick_gap(1'b0));
        push_request(1'b0, 64'h0000_0000_0000_0002, pick_gap(1'b0));

        // random insert sequences, each opened by a clear
        while (rnd_sent < RANDOM_REQS) begin
            seq_len = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 90)
                                                  : $urandom_range(1, 40);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (n = 0; n < seq_len && rnd_sent < RANDOM_REQS; n++) begin
                clr = (n == 0) || ($urandom_range(0, 59) == 0);
                if (clr) history.delete();
                kind = $urandom_range(0, 19);
                if (kind < 8 || kind > 17) begin
                    word = {$urandom, $urandom};
                end else if (kind < 10) begin
                    word = t_basis_word'(1) << $urandom_range(0, WIDTH - 1);
                end else if (kind == 10) begin
                    word = '0;
                    m    = $urandom_range(2, 3);
                    repeat (m) word |= t_basis_word'(1) << $urandom_range(0, WIDTH - 1);
                end else if (kind < 15) begin
                    if (history.size() == 0) begin
                        word = {$urandom, $urandom};
                    end else begin
                        word = '0;
                        m    = $urandom_range(1, 3);
                        repeat (m) word ^= history[$urandom_range(0, history.size() - 1)];
                    end
                end else if (kind == 15) begin
                    word = '0;
                end else begin
                    lo   = $urandom_range(0, WIDTH - 1);
                    hi   = $urandom_range(lo, WIDTH - 1);
                    word = {$urandom, $urandom} & (ones >> (WIDTH - 1 - hi)) & (ones << lo);
                end
                history = {history, word};
                push_request(clr, word, pick_gap(no_gaps));
                rnd_sent++;
                if (!drain_done && sent_total >= DRAIN_AT) begin
                    drain_done = 1'b1;
                    i_valid <= 1'b0;
                    while (sb.pending() != 0) @(posedge i_clk);
                end
            end
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/xbiq_pkg.sv
rtl/xbiq_cell.sv
rtl/xor_basis_insert_query.sv
tb/tb_xor_basis_insert_query.sv
